// ===== hdl/alu8f_pkg.sv =====
// ----------------------------------------------------------------------------
// alu8f_pkg
// Operation codes and flag bit positions for the eight-bit ALU with flags.
// ----------------------------------------------------------------------------
package alu8f_pkg;

   localparam int unsigned MODE_W  = 5;
   localparam int unsigned DATA_W  = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned BIDX_W  = 3;
   localparam int unsigned FLAGS_W = 4;

   // flag word layout
   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   localparam logic [BYTE_W-1:0] DAA_LIMIT = 8'h99;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD   = 5'd0,
      MODE_ADC   = 5'd1,
      MODE_SUB   = 5'd2,
      MODE_SBC   = 5'd3,
      MODE_AND   = 5'd4,
      MODE_XOR   = 5'd5,
      MODE_OR    = 5'd6,
      MODE_CP    = 5'd7,
      MODE_INC   = 5'd8,
      MODE_DEC   = 5'd9,
      MODE_RLCA  = 5'd10,
      MODE_RRCA  = 5'd11,
      MODE_RLA   = 5'd12,
      MODE_RRA   = 5'd13,
      MODE_DAA   = 5'd14,
      MODE_CPL   = 5'd15,
      MODE_SCF   = 5'd16,
      MODE_CCF   = 5'd17,
      MODE_RLC   = 5'd18,
      MODE_RRC   = 5'd19,
      MODE_RL    = 5'd20,
      MODE_RR    = 5'd21,
      MODE_SLA   = 5'd22,
      MODE_SRA   = 5'd23,
      MODE_SRL   = 5'd24,
      MODE_SWAP  = 5'd25,
      MODE_BIT   = 5'd26,
      MODE_RES   = 5'd27,
      MODE_SET   = 5'd28,
      MODE_ADD16 = 5'd29,
      MODE_ADDSP = 5'd30
   } mode_type;

endpackage

// ===== hdl/eight_bit_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags
// Arithmetic and logic unit of an 8-bit CPU with Z/N/H/C flags.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_*) carries one operation word: mode, two
//   operands, a bit index and the current flags. The response channel
//   (rsp_*) returns the result and the new flags, one word per request,
//   in order.
//   Both channels use valid/stall: a word moves on a clock edge where
//   valid is high and stall is low.
//   A request passes through the input register, then the ALU logic,
//   then the result register, which drives rsp_valid.
//   Throughput is one operation per cycle while rsp_stall is low; every
//   operation is a single pass through the logic.
//   When the receiver stalls, the result register holds its word and the
//   input register keeps one more; req_stall rises only once both are
//   full and rsp_stall is high.
//   Synchronous reset empties both registers; no word is in flight after
//   reset and the unit keeps no other state.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [alu8f_pkg::MODE_W-1:0]  req_mode,
   input  logic [alu8f_pkg::DATA_W-1:0]  req_a_operand,
   input  logic [alu8f_pkg::DATA_W-1:0]  req_b_operand,
   input  logic [alu8f_pkg::BIDX_W-1:0]  req_bit_index,
   input  logic [alu8f_pkg::FLAGS_W-1:0] req_flags_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [alu8f_pkg::DATA_W-1:0]  rsp_result,
   output logic [alu8f_pkg::FLAGS_W-1:0] rsp_flags_out
);
   import alu8f_pkg::*;

   function automatic logic zero8(input logic [BYTE_W-1:0] v);
      return (v == '0);
   endfunction

   // input register
   logic                 in_valid_ff;
   mode_type             mode_ff;
   logic [DATA_W-1:0]    a_ff;
   logic [DATA_W-1:0]    b_ff;
   logic [BIDX_W-1:0]    bidx_ff;
   logic [FLAGS_W-1:0]   flg_ff;

   // result register
   logic                 out_valid_ff;
   logic [DATA_W-1:0]    result_ff;
   logic [FLAGS_W-1:0]   flags_out_ff;
   logic [DATA_W-1:0]    result_in;
   logic [FLAGS_W-1:0]   flags_out_in;

   logic                 out_take;
   logic                 in_take;

   assign out_take  = !out_valid_ff || !rsp_stall;
   assign in_take   = !in_valid_ff || out_take;
   assign req_stall = !in_take;

   assign rsp_valid     = out_valid_ff;
   assign rsp_result    = result_ff;
   assign rsp_flags_out = flags_out_ff;

   // ALU datapath
   logic [BYTE_W-1:0]    a8;
   logic [BYTE_W-1:0]    b8;
   logic                 cf;
   logic                 is_sub;
   logic                 cin;
   logic [BYTE_W-1:0]    y8;
   logic [BYTE_W:0]      sum9;
   logic [4:0]           hsum5;
   logic [BYTE_W-1:0]    r8;
   logic [BYTE_W:0]      sp9;
   logic [4:0]           sph5;
   logic [DATA_W:0]      sum17;
   logic [12:0]          h13;
   logic [DATA_W-1:0]    sp_sum;
   logic [BYTE_W-1:0]    daa_off;
   logic                 daa_c;
   logic [BYTE_W-1:0]    bit_mask;

   always_comb begin
      a8       = a_ff[BYTE_W-1:0];
      b8       = b_ff[BYTE_W-1:0];
      cf       = flg_ff[FLAG_C];
      is_sub   = (mode_ff == MODE_SUB) || (mode_ff == MODE_SBC) || (mode_ff == MODE_CP);
      case (mode_ff)
         MODE_ADC: cin = cf;
         MODE_SUB: cin = 1'b1;
         MODE_SBC: cin = !cf;
         MODE_CP:  cin = 1'b1;
         default:  cin = 1'b0;
      endcase
      // subtract is add of the inverted operand; C and H flip afterwards
      y8       = is_sub ? ~b8 : b8;
      sum9     = {1'b0, a8} + {1'b0, y8} + {{BYTE_W{1'b0}}, cin};
      hsum5    = {1'b0, a8[3:0]} + {1'b0, y8[3:0]} + {4'b0, cin};
      sp9      = {1'b0, a8} + {1'b0, b8};
      sph5     = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
      sum17    = {1'b0, a_ff} + {1'b0, b_ff};
      h13      = {1'b0, a_ff[11:0]} + {1'b0, b_ff[11:0]};
      sp_sum   = a_ff + {{(DATA_W-BYTE_W){b8[BYTE_W-1]}}, b8};
      bit_mask = BYTE_W'(1) << bidx_ff;

      daa_off = '0;
      daa_c   = 1'b0;
      if ((!flg_ff[FLAG_N] && (a8[3:0] > 4'd9)) || flg_ff[FLAG_H])
         daa_off[3:0] = 4'h6;
      if ((!flg_ff[FLAG_N] && (a8 > DAA_LIMIT)) || cf) begin
         daa_off[7:4] = 4'h6;
         daa_c        = 1'b1;
      end

      r8           = a8;
      flags_out_in = flg_ff;
      result_in    = '0;

      unique case (mode_ff) inside
         MODE_ADD, MODE_ADC: begin
            r8           = sum9[BYTE_W-1:0];
            flags_out_in = {zero8(r8), 1'b0, hsum5[4], sum9[BYTE_W]};
         end
         MODE_SUB, MODE_SBC: begin
            r8           = sum9[BYTE_W-1:0];
            flags_out_in = {zero8(r8), 1'b1, !hsum5[4], !sum9[BYTE_W]};
         end
         MODE_CP: begin
            flags_out_in = {zero8(sum9[BYTE_W-1:0]), 1'b1, !hsum5[4], !sum9[BYTE_W]};
         end
         MODE_AND: begin
            r8           = a8 & b8;
            flags_out_in = {zero8(r8), 1'b0, 1'b1, 1'b0};
         end
         MODE_XOR: begin
            r8           = a8 ^ b8;
            flags_out_in = {zero8(r8), 3'b000};
         end
         MODE_OR: begin
            r8           = a8 | b8;
            flags_out_in = {zero8(r8), 3'b000};
         end
         MODE_INC: begin
            r8           = a8 + 8'd1;
            flags_out_in = {zero8(r8), 1'b0, (r8[3:0] == 4'h0), cf};
         end
         MODE_DEC: begin
            r8           = a8 - 8'd1;
            flags_out_in = {zero8(r8), 1'b1, (r8[3:0] == 4'hF), cf};
         end
         MODE_RLCA: begin
            r8           = {a8[6:0], a8[7]};
            flags_out_in = {3'b000, a8[7]};
         end
         MODE_RLC: begin
            r8           = {a8[6:0], a8[7]};
            flags_out_in = {zero8(r8), 2'b00, a8[7]};
         end
         MODE_RRCA: begin
            r8           = {a8[0], a8[7:1]};
            flags_out_in = {3'b000, a8[0]};
         end
         MODE_RRC: begin
            r8           = {a8[0], a8[7:1]};
            flags_out_in = {zero8(r8), 2'b00, a8[0]};
         end
         MODE_RLA: begin
            r8           = {a8[6:0], cf};
            flags_out_in = {3'b000, a8[7]};
         end
         MODE_RL: begin
            r8           = {a8[6:0], cf};
            flags_out_in = {zero8(r8), 2'b00, a8[7]};
         end
         MODE_RRA: begin
            r8           = {cf, a8[7:1]};
            flags_out_in = {3'b000, a8[0]};
         end
         MODE_RR: begin
            r8           = {cf, a8[7:1]};
            flags_out_in = {zero8(r8), 2'b00, a8[0]};
         end
         MODE_DAA: begin
            r8           = flg_ff[FLAG_N] ? (a8 - daa_off) : (a8 + daa_off);
            flags_out_in = {zero8(r8), flg_ff[FLAG_N], 1'b0, daa_c};
         end
         MODE_CPL: begin
            r8           = ~a8;
            flags_out_in = flg_ff | 4'b0110;
         end
         MODE_SCF: begin
            flags_out_in = {flg_ff[FLAG_Z], 3'b001};
         end
         MODE_CCF: begin
            flags_out_in = {flg_ff[FLAG_Z], 2'b00, !cf};
         end
         MODE_SLA: begin
            r8           = {a8[6:0], 1'b0};
            flags_out_in = {zero8(r8), 2'b00, a8[7]};
         end
         MODE_SRA: begin
            r8           = {a8[7], a8[7:1]};
            flags_out_in = {zero8(r8), 2'b00, a8[0]};
         end
         MODE_SRL: begin
            r8           = {1'b0, a8[7:1]};
            flags_out_in = {zero8(r8), 2'b00, a8[0]};
         end
         MODE_SWAP: begin
            r8           = {a8[3:0], a8[7:4]};
            flags_out_in = {zero8(r8), 3'b000};
         end
         MODE_BIT: begin
            flags_out_in = {!a8[bidx_ff], 1'b0, 1'b1, cf};
         end
         MODE_RES: begin
            r8 = a8 & ~bit_mask;
         end
         MODE_SET: begin
            r8 = a8 | bit_mask;
         end
         MODE_ADD16, MODE_ADDSP: begin
         end
         default: begin
         end
      endcase

      // 8-bit modes return the byte zero-extended; wide modes override
      result_in = {{(DATA_W-BYTE_W){1'b0}}, r8};
      case (mode_ff) inside
         MODE_ADD16: begin
            result_in    = sum17[DATA_W-1:0];
            flags_out_in = {flg_ff[FLAG_Z], 1'b0, h13[12], sum17[DATA_W]};
         end
         MODE_ADDSP: begin
            result_in    = sp_sum;
            flags_out_in = {2'b00, sph5[4], sp9[BYTE_W]};
         end
         MODE_ADD, MODE_ADC, MODE_SUB, MODE_SBC, MODE_AND, MODE_XOR, MODE_OR,
         MODE_CP, MODE_INC, MODE_DEC, MODE_RLCA, MODE_RRCA, MODE_RLA, MODE_RRA,
         MODE_DAA, MODE_CPL, MODE_SCF, MODE_CCF, MODE_RLC, MODE_RRC, MODE_RL,
         MODE_RR, MODE_SLA, MODE_SRA, MODE_SRL, MODE_SWAP, MODE_BIT, MODE_RES,
         MODE_SET: begin
         end
         default: begin
            // unused code passes the word through
            result_in    = a_ff;
            flags_out_in = flg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_take)
            in_valid_ff <= req_valid;
         if (out_take)
            out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && req_valid) begin
         mode_ff <= mode_type'(req_mode);
         a_ff    <= req_a_operand;
         b_ff    <= req_b_operand;
         bidx_ff <= req_bit_index;
         flg_ff  <= req_flags_in;
      end
      if (out_take && in_valid_ff) begin
         result_ff    <= result_in;
         flags_out_ff <= flags_out_in;
      end
   end

endmodule
